/* hw/rtl/csp_pkg.sv */
// Shared types, constants and arithmetic helpers of the cubic spline piece evaluator.
package csp_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SPAN_W      = IDX_W + 1;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ADD_W       = DATA_W + 1;
   localparam int SUM_W       = PROD_W - FRAC_BITS + 8;
   localparam int KR_W        = FRAC_BITS + 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [IDX_W-1:0]         entry_index;
      logic signed [DATA_W-1:0] knot_position;
      logic signed [DATA_W-1:0] cubic_coef;
      logic signed [DATA_W-1:0] square_coef;
      logic signed [DATA_W-1:0] linear_coef;
      logic signed [DATA_W-1:0] constant_coef;
      logic signed [DATA_W-1:0] query_position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] slope;
      logic signed [DATA_W-1:0] curvature;
      logic [IDX_W-1:0]         piece_index;
      logic                     overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] c3;
      logic signed [DATA_W-1:0] c2;
      logic signed [DATA_W-1:0] c1;
      logic signed [DATA_W-1:0] c0;
   } coef_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     ov;
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SPAN,
      ST_MID,
      ST_PIECE_RD,
      ST_DIFF,
      ST_MUL_C3,
      ST_POST_C3,
      ST_MUL_Y1,
      ST_POST_Y1,
      ST_MUL_Y2,
      ST_POST_Y2,
      ST_MUL_S,
      ST_POST_S,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {ADDR_ZERO, ADDR_LAST, ADDR_MID, ADDR_PIECE} addr_sel_type;
   typedef enum logic [1:0] {PIECE_KEEP, PIECE_BASE, PIECE_LAST} piece_sel_type;
   typedef enum logic [1:0] {MUL_NONE, MUL_C3, MUL_Y, MUL_S} mul_sel_type;
   typedef enum logic [2:0] {POST_NONE, POST_C3, POST_C1_Y, POST_C0_Y, POST_C1_S} post_sel_type;
   typedef enum logic [1:0] {K_ONE, K_THREE, K_SIX} mul_k_type;

   typedef struct packed {
      logic          wr_en;
      logic          rd_en;
      addr_sel_type  addr_sel;
      logic          load_query;
      piece_sel_type piece_sel;
      logic          step_range;
      logic          calc_diff;
      mul_sel_type   mul_sel;
      post_sel_type  post_sel;
      logic          load_out;
   } cmd_type;

   typedef struct packed {
      logic few_knots;
      logic x_lt_knot;
      logic span_small;
   } status_type;

   // Clamp a wide signed sum to the data width, flag if clamped.
   function automatic res_type sat_data(input logic signed [SUM_W-1:0] sum);
      res_type res;
      res.ov  = !((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]));
      res.val = sum[DATA_W-1:0];
      if (res.ov) begin
         res.val = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

   // k * prod / 2^F rounded to nearest (ties up), plus addend, then saturated.
   function automatic res_type round_sat(input logic signed [PROD_W-1:0] prod,
                                         input mul_k_type k,
                                         input logic signed [ADD_W-1:0] addend);
      logic signed [SUM_W-1:0] q;
      logic signed [SUM_W-1:0] kq;
      logic signed [SUM_W-1:0] carry;
      logic signed [SUM_W-1:0] sum;
      logic [KR_W-1:0]         r;
      logic [KR_W-1:0]         kr;
      logic [KR_W-1:0]         t;
      q = SUM_W'(prod >>> FRAC_BITS);
      r = KR_W'(prod[FRAC_BITS-1:0]);
      case (k)
         K_THREE: begin
            kq = (q <<< 1) + q;
            kr = (r << 1) + r;
         end
         K_SIX: begin
            kq = (q <<< 2) + (q <<< 1);
            kr = (r << 2) + (r << 1);
         end
         default: begin
            kq = q;
            kr = r;
         end
      endcase
      t     = kr + (KR_W'(1) << (FRAC_BITS - 1));
      carry = signed'(SUM_W'(t >> FRAC_BITS));
      sum   = kq + carry + SUM_W'(addend);
      return sat_data(sum);
   endfunction

endpackage

/* hw/rtl/csp_ctrl.sv */
// Sequencer of the cubic spline piece evaluator: search, evaluation and result hand-off.
module csp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  csp_pkg::status_type  status,
   output csp_pkg::cmd_type     cmd
);
   import csp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_op == OP_EVAL) begin
               state_in = status.few_knots ? ST_PIECE_RD : ST_FIRST;
            end
         end
         ST_FIRST:    state_in = status.x_lt_knot ? ST_PIECE_RD : ST_LAST;
         ST_LAST:     state_in = status.x_lt_knot ? ST_SPAN : ST_PIECE_RD;
         ST_SPAN:     state_in = status.span_small ? ST_PIECE_RD : ST_MID;
         ST_MID:      state_in = ST_SPAN;
         ST_PIECE_RD: state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_MUL_C3;
         ST_MUL_C3:   state_in = ST_POST_C3;
         ST_POST_C3:  state_in = ST_MUL_Y1;
         ST_MUL_Y1:   state_in = ST_POST_Y1;
         ST_POST_Y1:  state_in = ST_MUL_Y2;
         ST_MUL_Y2:   state_in = ST_POST_Y2;
         ST_POST_Y2:  state_in = ST_MUL_S;
         ST_MUL_S:    state_in = ST_POST_S;
         ST_POST_S:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{wr_en: 1'b0, rd_en: 1'b0, addr_sel: ADDR_ZERO, load_query: 1'b0,
              piece_sel: PIECE_KEEP, step_range: 1'b0, calc_diff: 1'b0,
              mul_sel: MUL_NONE, post_sel: POST_NONE, load_out: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            cmd.rd_en      = 1'b1;
            cmd.addr_sel   = ADDR_ZERO;
            cmd.wr_en      = req_valid && req_op == OP_WRITE;
            cmd.load_query = req_valid && req_op == OP_EVAL;
         end
         ST_FIRST: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_LAST;
            if (status.x_lt_knot) begin
               cmd.piece_sel = PIECE_BASE;
            end
         end
         ST_LAST: begin
            if (!status.x_lt_knot) begin
               cmd.piece_sel = PIECE_LAST;
            end
         end
         ST_SPAN: begin
            if (status.span_small) begin
               cmd.piece_sel = PIECE_BASE;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_MID;
            end
         end
         ST_MID:      cmd.step_range = 1'b1;
         ST_PIECE_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = ADDR_PIECE;
         end
         ST_DIFF:     cmd.calc_diff = 1'b1;
         ST_MUL_C3:   cmd.mul_sel = MUL_C3;
         ST_POST_C3:  cmd.post_sel = POST_C3;
         ST_MUL_Y1:   cmd.mul_sel = MUL_Y;
         ST_POST_Y1:  cmd.post_sel = POST_C1_Y;
         ST_MUL_Y2:   cmd.mul_sel = MUL_Y;
         ST_POST_Y2:  cmd.post_sel = POST_C0_Y;
         ST_MUL_S:    cmd.mul_sel = MUL_S;
         ST_POST_S:   cmd.post_sel = POST_C1_S;
         ST_OUT:      cmd.load_out = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/csp_datapath.sv */
// Tables, search range, shared multiplier and result registers of the spline evaluator.
module csp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  csp_pkg::req_type                req_data,
   input  logic                            csr_wr_en,
   input  logic [csp_pkg::IDX_W-1:0]       csr_wr_data,
   input  csp_pkg::cmd_type                cmd,
   output csp_pkg::status_type             status,
   output csp_pkg::rsp_type                rsp_data
);
   import csp_pkg::*;

   logic signed [DATA_W-1:0] knot_mem [TABLE_DEPTH];
   coef_type                 coef_mem [TABLE_DEPTH];

   logic [IDX_W-1:0]         pc_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] knot_rd_ff;
   coef_type                 coef_rd_ff;

   logic signed [DATA_W-1:0] x_ff, x_in;
   logic [IDX_W-1:0]         b_ff, b_in;
   logic [SPAN_W-1:0]        e_ff, e_in;
   logic [IDX_W-1:0]         piece_ff, piece_in;
   logic signed [DATA_W-1:0] d_ff, d_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic signed [DATA_W-1:0] s_ff, s_in;
   logic signed [DATA_W-1:0] k_ff, k_in;
   logic                     ov_ff, ov_in;
   rsp_type                  out_ff, out_in;

   logic [SPAN_W-1:0]        span;
   logic [IDX_W-1:0]         mid;
   logic signed [ADD_W-1:0]  diff;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [ADD_W-1:0]  two_c2;
   res_type                  d_res, r3, r6;
   res_type                  res_tmp;

   assign span = e_ff - SPAN_W'(b_ff);
   assign mid  = IDX_W'(SPAN_W'(b_ff) + (span >> 1));

   assign status.few_knots  = (pc_ff <= IDX_W'(1));
   assign status.x_lt_knot  = (x_ff < knot_rd_ff);
   assign status.span_small = (span <= SPAN_W'(2));

   always_comb begin
      case (cmd.addr_sel)
         ADDR_LAST:  rd_addr = pc_ff;
         ADDR_MID:   rd_addr = mid;
         ADDR_PIECE: rd_addr = piece_ff;
         default:    rd_addr = '0;
      endcase
   end

   // Tables: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         knot_mem[req_data.entry_index] <= req_data.knot_position;
         coef_mem[req_data.entry_index] <= '{c3: req_data.cubic_coef,
                                             c2: req_data.square_coef,
                                             c1: req_data.linear_coef,
                                             c0: req_data.constant_coef};
      end
      if (cmd.rd_en) begin
         knot_rd_ff <= knot_mem[rd_addr];
         coef_rd_ff <= coef_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= IDX_W'(1);
      end else if (csr_wr_en) begin
         pc_ff <= csr_wr_data;
      end
   end

   assign diff   = {x_ff[DATA_W-1], x_ff} - {knot_rd_ff[DATA_W-1], knot_rd_ff};
   assign d_res  = sat_data(SUM_W'(diff));
   assign two_c2 = {coef_rd_ff.c2, 1'b0};

   always_comb begin
      case (cmd.mul_sel)
         MUL_Y:   mul_a = y_ff;
         MUL_S:   mul_a = s_ff;
         default: mul_a = coef_rd_ff.c3;
      endcase
   end

   assign r3 = round_sat(prod_ff, K_THREE, two_c2);
   assign r6 = round_sat(prod_ff, K_SIX, two_c2);

   always_comb begin
      x_in     = x_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      piece_in = piece_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      y_in     = y_ff;
      s_in     = s_ff;
      k_in     = k_ff;
      ov_in    = ov_ff;
      out_in   = out_ff;
      res_tmp  = '0;

      if (cmd.load_query) begin
         x_in     = req_data.query_position;
         b_in     = '0;
         e_in     = SPAN_W'(pc_ff) + SPAN_W'(1);
         piece_in = '0;
         ov_in    = 1'b0;
      end

      case (cmd.piece_sel)
         PIECE_BASE: piece_in = b_ff;
         PIECE_LAST: piece_in = pc_ff - IDX_W'(1);
         default: begin
         end
      endcase

      // Narrow the range on the middle knot.
      if (cmd.step_range) begin
         if (!status.x_lt_knot) begin
            b_in = mid;
         end else begin
            e_in = SPAN_W'(mid) + SPAN_W'(1);
         end
      end

      if (cmd.calc_diff) begin
         d_in  = d_res.val;
         ov_in = ov_ff | d_res.ov;
      end

      if (cmd.mul_sel != MUL_NONE) begin
         prod_in = mul_a * d_ff;
      end

      case (cmd.post_sel)
         POST_C3: begin
            res_tmp = round_sat(prod_ff, K_ONE, ADD_W'(coef_rd_ff.c2));
            y_in    = res_tmp.val;
            s_in    = r3.val;
            k_in    = r6.val;
            ov_in   = ov_ff | res_tmp.ov | r3.ov | r6.ov;
         end
         POST_C1_Y: begin
            res_tmp = round_sat(prod_ff, K_ONE, ADD_W'(coef_rd_ff.c1));
            y_in    = res_tmp.val;
            ov_in   = ov_ff | res_tmp.ov;
         end
         POST_C0_Y: begin
            res_tmp = round_sat(prod_ff, K_ONE, ADD_W'(coef_rd_ff.c0));
            y_in    = res_tmp.val;
            ov_in   = ov_ff | res_tmp.ov;
         end
         POST_C1_S: begin
            res_tmp = round_sat(prod_ff, K_ONE, ADD_W'(coef_rd_ff.c1));
            s_in    = res_tmp.val;
            ov_in   = ov_ff | res_tmp.ov;
         end
         default: begin
         end
      endcase

      if (cmd.load_out) begin
         out_in = '{value: y_ff, slope: s_ff, curvature: k_ff,
                    piece_index: piece_ff, overflow: ov_ff};
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      b_ff     <= b_in;
      e_ff     <= e_in;
      piece_ff <= piece_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      y_ff     <= y_in;
      s_ff     <= s_in;
      k_ff     <= k_in;
      ov_ff    <= ov_in;
      out_ff   <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

/* hw/rtl/cubic_spline_piece_evaluator.sv */
// Top level of the cubic spline piece evaluator: sequencer plus datapath.
//
// Evaluates a piecewise cubic spline held in two on-chip tables (64 knots,
// 64 sets of four Q16.16 coefficients). A word with op = write stores knot
// and coefficients at entry_index and is taken with no result word. A word
// with op = evaluate locates the piece by binary search over the
// first piece_count + 1 knots (below the first knot: piece 0; at or past the
// last knot: last piece, extrapolated; two knots or fewer: piece 0) and gives
// value, slope and curvature at the offset from that piece's start knot by
// Horner's rule, each product rounded to nearest with ties upwards and each
// sum saturated to 32 bits; overflow reports any saturation, the offset
// included. An evaluate word takes longer with a full search over 64 knots
// than with few knots: the knot table has one read port, so each search
// step costs a read and a compare, and the single 32 x 32 multiplier is
// used four times, each product registered before rounding.
// The block takes one word at a time; a finished result waits in an output
// register, and the next word is accepted while it waits. Write piece_count
// only while the block is idle; table entries must be written before use.
module cubic_spline_piece_evaluator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  csp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output csp_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [csp_pkg::IDX_W-1:0]  csr_wr_data
);
   import csp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: owns the handshakes and steps the datapath.
   csp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: tables, search range, multiplier and output register.
   csp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

/* test/tb_cubic_spline_piece_evaluator.sv */
// Testbench of the spline evaluator: directed words, then random phases against a predictor.
`timescale 1ns / 1ps

module tb_cubic_spline_piece_evaluator;

   import csp_pkg::*;

   localparam int     CLOCK_HALF   = 5;
   localparam int     RESET_CYCLES = 10;
   // Wait well past the longest evaluate before touching piece_count.
   localparam int     DRAIN_CYCLES = 40;
   localparam int     PHASES       = 8;
   localparam int     PHASE_WORDS  = 60;
   localparam int     LOG_LIMIT    = 100;
   localparam int     TIMEOUT_NS   = 3_000_000;
   localparam longint WORD_MAX     = 64'sd2147483647;
   localparam longint WORD_MIN     = -WORD_MAX - 1;

   // How the knots of a phase are laid out.
   typedef enum int {KNOTS_DENSE, KNOTS_WIDE, KNOTS_TIED} knot_style_type;

   // One line of the directed script: the word, and optionally a hand-worked result.
   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type want;
   } script_row_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_type            req_data    = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [IDX_W-1:0]   csr_wr_data = '0;

   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 coef_wild_pct  = 4;
   int                 mismatch_count = 0;

   // Shadow copy of the block: knot and coefficient tables plus piece_count.
   longint             knot_mem [TABLE_DEPTH];
   coef_type           coef_mem [TABLE_DEPTH];
   int                 pieces_in_use = 1;
   rsp_type            pending_results [$];
   script_row_type     script [$];

   cubic_spline_piece_evaluator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Clamp to the signed 32-bit range, raising the overflow flag if clamped.
   function automatic longint clamp_word(input longint v, inout bit ov);
      if (v > WORD_MAX) begin
         ov = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_MIN) begin
         ov = 1'b1;
         return WORD_MIN;
      end
      return v;
   endfunction

   // m * a * b / 2^F, rounded to nearest with ties towards +infinity.
   // Split the product so the rounding carry of m * fraction is exact.
   function automatic longint round_product(input longint a, input longint b, input longint m);
      longint p;
      longint whole;
      longint frac;
      longint t;
      p     = a * b;
      whole = p >>> FRAC_BITS;
      frac  = p & ((longint'(1) <<< FRAC_BITS) - 1);
      t     = m * frac + (longint'(1) <<< (FRAC_BITS - 1));
      return m * whole + (t >>> FRAC_BITS);
   endfunction

   // Binary search over the knots in use. Narrow while the query lies strictly
   // inside the range; below the first knot, or with two knots or fewer, take
   // the low end; at or past the last knot, take the last piece.
   function automatic int locate_piece(input longint x);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = (pieces_in_use + 1 > TABLE_DEPTH) ? TABLE_DEPTH : pieces_in_use + 1;
      while (hi - lo > 2 && x >= knot_mem[lo] && x < knot_mem[hi - 1]) begin
         mid = lo + (hi - lo) / 2;
         if (x >= knot_mem[mid]) begin
            lo = mid;
         end else begin
            hi = mid + 1;
         end
      end
      if (hi - lo <= 2 || x < knot_mem[lo]) begin
         return lo;
      end
      return hi - 2;
   endfunction

   // Value, slope and curvature by Horner's rule at the offset from the piece's knot.
   function automatic rsp_type evaluate_spline(input longint x);
      rsp_type  res;
      coef_type c;
      int       p;
      bit       ov;
      longint   d;
      longint   c3;
      longint   c2;
      longint   c1;
      longint   c0;
      longint   y;
      longint   s;
      longint   k;
      ov = 1'b0;
      p  = locate_piece(x);
      c  = coef_mem[p];
      c3 = longint'(c.c3);
      c2 = longint'(c.c2);
      c1 = longint'(c.c1);
      c0 = longint'(c.c0);
      d  = clamp_word(x - knot_mem[p], ov);
      y  = clamp_word(round_product(c3, d, 1) + c2, ov);
      y  = clamp_word(round_product(y, d, 1) + c1, ov);
      y  = clamp_word(round_product(y, d, 1) + c0, ov);
      s  = clamp_word(round_product(c3, d, 3) + 2 * c2, ov);
      s  = clamp_word(round_product(s, d, 1) + c1, ov);
      k  = clamp_word(round_product(c3, d, 6) + 2 * c2, ov);
      res.value       = 32'(y);
      res.slope       = 32'(s);
      res.curvature   = 32'(k);
      res.piece_index = IDX_W'(p);
      res.overflow    = ov;
      return res;
   endfunction

   // Update the shadow tables on a write word; queue the result of an evaluate word.
   function automatic void apply_word(input req_type w, input bit fixed, input rsp_type want);
      if (w.op == OP_WRITE) begin
         knot_mem[w.entry_index]    = longint'(w.knot_position);
         coef_mem[w.entry_index].c3 = w.cubic_coef;
         coef_mem[w.entry_index].c2 = w.square_coef;
         coef_mem[w.entry_index].c1 = w.linear_coef;
         coef_mem[w.entry_index].c0 = w.constant_coef;
      end else begin
         pending_results.push_back(fixed ? want : evaluate_spline(longint'(w.query_position)));
      end
   endfunction

   // ---------------------------------------------------------------- checking

   // Count every mismatch; print only the first LOG_LIMIT to keep the log short.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= LOG_LIMIT) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result word %h with nothing expected", got));
         return;
      end
      want = pending_results.pop_front();
      compare_field("value", got.value, want.value);
      compare_field("slope", got.slope, want.slope);
      compare_field("curvature", got.curvature, want.curvature);
      compare_field("piece_index", 32'(got.piece_index), 32'(want.piece_index));
      compare_field("overflow", 32'(got.overflow), 32'(want.overflow));
   endtask

   // Receiver: take result words, stalling at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one word: idle first at the sender's rate, then hold valid and the
   // payload steady until the handshake, and predict at the accepting edge.
   task automatic push_word(input req_type w, input bit fixed = 1'b0,
                            input rsp_type want = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      apply_word(w, fixed, want);
   endtask

   // Drop valid, wait for every expected word, then let the block go quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_piece_count(input int n);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= IDX_W'(n);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pieces_in_use = n;
   endtask

   // Every field random, so the ignored fields toggle as well.
   function automatic req_type random_word();
      req_type w;
      w.op             = 1'($urandom);
      w.entry_index    = IDX_W'($urandom);
      w.knot_position  = $urandom;
      w.cubic_coef     = $urandom;
      w.square_coef    = $urandom;
      w.linear_coef    = $urandom;
      w.constant_coef  = $urandom;
      w.query_position = $urandom;
      return w;
   endfunction

   // Mostly small coefficients (about +-2.0) so that results often stay in range.
   function automatic logic [31:0] pick_coef();
      int r;
      r = $urandom_range(99);
      if (r < 4) begin
         return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      if (r < 4 + coef_wild_pct) begin
         return $urandom;
      end
      return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
   endfunction

   function automatic req_type with_new_coefs(input req_type w);
      w.cubic_coef    = pick_coef();
      w.square_coef   = pick_coef();
      w.linear_coef   = pick_coef();
      w.constant_coef = pick_coef();
      return w;
   endfunction

   // Fill every entry in use with non-decreasing knots before any query of the phase,
   // so that no evaluate ever reads an entry that was never written.
   task automatic load_table(input knot_style_type style);
      req_type w;
      longint  knot_at;
      longint  pitch;
      int      knots;
      knots   = pieces_in_use + 1;
      pitch   = longint'(32'hFFFF_FFFF) / knots;
      knot_at = longint'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      for (int i = 0; i < knots; i++) begin
         // Spread the knots over the whole number range, jittered within half a pitch.
         if (style == KNOTS_WIDE) begin
            knot_at = WORD_MIN + i * pitch + longint'($urandom) % (pitch / 2);
         end
         w = with_new_coefs(random_word());
         w.op            = OP_WRITE;
         w.entry_index   = IDX_W'(i);
         w.knot_position = 32'(knot_at);
         push_word(w);
         if (style == KNOTS_DENSE) begin
            knot_at += $urandom_range(1, 1 << 17);
         end else if (style == KNOTS_TIED) begin
            // Steps of zero leave equal knots side by side.
            knot_at += $urandom_range(0, 3);
         end
      end
   endtask

   // Query position: mostly inside a piece or on a knot, the rest outside the
   // knots, at the number range's ends, or anywhere.
   function automatic longint pick_query();
      int     knots;
      int     j;
      int     r;
      longint lo;
      longint span;
      knots = pieces_in_use + 1;
      r     = $urandom_range(99);
      if (r < 40) begin
         j    = $urandom_range(0, knots - 2);
         lo   = knot_mem[j];
         span = knot_mem[j + 1] - lo;
         return (span > 0) ? lo + longint'($urandom) % span : lo;
      end
      if (r < 55) begin
         return knot_mem[$urandom_range(0, knots - 1)];
      end
      if (r < 65) begin
         lo = knot_mem[0];
         return (lo > WORD_MIN) ? WORD_MIN + longint'($urandom) % (lo - WORD_MIN) : WORD_MIN;
      end
      if (r < 75) begin
         lo = knot_mem[knots - 1];
         return lo + longint'($urandom) % (WORD_MAX - lo + 1);
      end
      if (r < 82) begin
         case ($urandom_range(3))
            0: begin
               return WORD_MIN;
            end
            1: begin
               return WORD_MAX;
            end
            2: begin
               return 0;
            end
            default: begin
               return -1;
            end
         endcase
      end
      return longint'(int'($urandom));
   endfunction

   // Mostly evaluates; some coefficient rewrites that keep the knots in order,
   // and a few wholly random writes that may leave them out of order.
   task automatic random_item();
      req_type w;
      int      r;
      int      idx;
      w = random_word();
      r = $urandom_range(99);
      if (r < 12) begin
         idx = $urandom_range(0, pieces_in_use);
         w = with_new_coefs(w);
         w.op            = OP_WRITE;
         w.entry_index   = IDX_W'(idx);
         w.knot_position = 32'(knot_mem[idx]);
      end else if (r < 15) begin
         w.op = OP_WRITE;
      end else begin
         w.op             = OP_EVAL;
         w.query_position = 32'(pick_query());
      end
      push_word(w);
   endtask

   // ---------------------------------------------------------------- directed script

   function automatic void add_write(input int idx, input logic [31:0] knot,
                                     input logic [31:0] c3, input logic [31:0] c2,
                                     input logic [31:0] c1, input logic [31:0] c0);
      script_row_type row;
      row.word               = '0;
      row.word.op            = OP_WRITE;
      row.word.entry_index   = IDX_W'(idx);
      row.word.knot_position = knot;
      row.word.cubic_coef    = c3;
      row.word.square_coef   = c2;
      row.word.linear_coef   = c1;
      row.word.constant_coef = c0;
      row.fixed              = 1'b0;
      row.want               = '0;
      script.push_back(row);
   endfunction

   // The directed words run with two knots, so every query lands on piece 0.
   function automatic void add_query(input logic [31:0] x, input bit fixed,
                                     input logic [31:0] v = '0, input logic [31:0] s = '0,
                                     input logic [31:0] k = '0, input logic ov = 1'b0);
      script_row_type row;
      row.word                = '0;
      row.word.op             = OP_EVAL;
      row.word.query_position = x;
      row.fixed               = fixed;
      row.want                = '0;
      row.want.value          = v;
      row.want.slope          = s;
      row.want.curvature      = k;
      row.want.overflow       = ov;
      script.push_back(row);
   endfunction

   // ---------------------------------------------------------------- main sequence

   initial begin
      // Reset value of piece_count (one piece): a constant 1.0 everywhere,
      // below the first knot and past the last one alike.
      add_write(0, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
      add_write(1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      add_query(32'h0000_0000, 1'b1, 32'h0001_0000);
      add_query(32'h7FFF_FFFF, 1'b1, 32'h0001_0000);
      add_query(32'h8000_0000, 1'b1, 32'h0001_0000);
      // Offset from the lowest knot to the highest query saturates.
      add_write(0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0000_0005);
      add_query(32'h7FFF_FFFF, 1'b1, 32'h0000_0005, 32'h0, 32'h0, 1'b1);
      // Doubled square coefficient saturates high, then low.
      add_write(0, 32'h0000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
      add_query(32'h0000_0000, 1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1);
      add_write(0, 32'h0000_0000, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
      add_query(32'h0000_0000, 1'b1, 32'h0, 32'h0, 32'h8000_0000, 1'b1);
      // Pure cube: x^3, 3x^2 and 6x at x = 2.0 and x = -1.0.
      add_write(0, 32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      add_query(32'h0002_0000, 1'b1, 32'h0008_0000, 32'h000C_0000, 32'h000C_0000);
      add_query(32'hFFFF_0000, 1'b1, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFA_0000);
      // Rounding ties go towards +infinity: +half rounds up, -half rounds to zero.
      add_write(0, 32'h0000_0000, 32'h0, 32'h0, 32'h0000_0001, 32'h0);
      add_query(32'h0000_8000, 1'b1, 32'h0000_0001, 32'h0000_0001);
      add_write(0, 32'h0000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
      add_query(32'h0000_8000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      // A general piece, left to the predictor.
      add_write(0, 32'h0003_0000, 32'hFFFE_8000, 32'h0001_2345, 32'hFFF0_0001, 32'h7FFF_0000);
      add_query(32'h0005_7000, 1'b0);
      add_query(32'h8000_0001, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         push_word(script[i].word, script[i].fixed, script[i].want);
      end

      // Random phases: piece count from one to the full table, knot layouts
      // and idling patterns rotating at different periods so that they meet in varied pairs.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 46;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 46;
            end
            default: begin
               send_idle_pct  = 7;
               recv_stall_pct = 7;
            end
         endcase
         coef_wild_pct = (ph % 2) ? 30 : 4;
         case (ph)
            0, 4: begin
               write_piece_count(63);
            end
            1: begin
               write_piece_count(1);
            end
            2: begin
               write_piece_count(2);
            end
            3: begin
               write_piece_count(3);
            end
            5: begin
               write_piece_count(17);
            end
            6: begin
               write_piece_count(32);
            end
            default: begin
               write_piece_count($urandom_range(4, 62));
            end
         endcase
         load_table(knot_style_type'(ph % 3));
         repeat (PHASE_WORDS) random_item();
      end

      drain();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #TIMEOUT_NS;
      $display("timeout with %0d result words outstanding", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
